>>> rtl/todu_pkg.sv
package todu_pkg;

  // one sample every 2^SAMPLE_EVERY_LOG2 ticks (0..8)
  localparam int SAMPLE_EVERY_LOG2 = 2;
  localparam int PHASE_W = (SAMPLE_EVERY_LOG2 == 0) ? 1 : SAMPLE_EVERY_LOG2;
  localparam logic [PHASE_W-1:0] PHASE_MASK = PHASE_W'((1 << SAMPLE_EVERY_LOG2) - 1);

  localparam int AXIS_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // register reset values, Q15
  localparam logic [15:0] CHANGE_LIMIT_RST = 16'd3277;  // 0.1
  localparam logic [15:0] FLAT_LIMIT_RST   = 16'd29491; // 0.9
  localparam logic [15:0] DEAD_BAND_RST    = 16'd3277;  // 0.1

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDE_SCREEN  = 2'd0,
    REG_CHANGE_LIMIT = 2'd1,
    REG_FLAT_LIMIT   = 2'd2,
    REG_DEAD_BAND    = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ORIENT_X_POS = 2'd0,
    ORIENT_Y_NEG = 2'd1,
    ORIENT_X_NEG = 2'd2,
    ORIENT_Y_POS = 2'd3
  } orient_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] value;   // stored sample
    logic [AXIS_W-1:0]        mag;     // |value|, 0..32768
    logic                     too_far; // change beyond limit
  } lane_res_t;

  typedef struct packed {
    orient_t    orientation;
    logic       request;
    logic [1:0] code;
  } decision_t;

  typedef struct packed {
    orient_t    orientation;
    logic       sampled;
    logic       request;
    logic [1:0] code;
  } out_item_t;

  function automatic logic [AXIS_W-1:0] abs16(input logic signed [AXIS_W-1:0] v);
    logic [AXIS_W-1:0] u;
    u = v;
    return v[AXIS_W-1] ? (~u + 16'd1) : u;
  endfunction

  // tall display: quarter turns per orientation
  function automatic logic [1:0] tall_map(input orient_t o);
    logic [1:0] c;
    case (o)
      ORIENT_X_POS: c = 2'd1;
      ORIENT_Y_NEG: c = 2'd2;
      ORIENT_X_NEG: c = 2'd3;
      ORIENT_Y_POS: c = 2'd0;
      default:      c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/todu_axis_lane.sv
module todu_axis_lane (
  input  logic signed [15:0] axis,
  input  logic               negate,
  input  logic signed [15:0] last,
  input  logic [15:0]        change_limit,
  output todu_pkg::lane_res_t res
);

  logic signed [15:0] neg_sat;
  logic signed [15:0] value;
  logic [15:0]        mag_now;
  logic [15:0]        mag_last;
  logic [16:0]        diff;
  logic [16:0]        diff_abs;

  // -(-32768) clips to 32767
  assign neg_sat  = (axis == 16'sh8000) ? 16'sh7fff : -axis;
  assign value    = negate ? neg_sat : axis;
  assign mag_now  = todu_pkg::abs16(value);
  assign mag_last = todu_pkg::abs16(last);
  assign diff     = {1'b0, mag_last} - {1'b0, mag_now};
  assign diff_abs = diff[16] ? (~diff + 17'd1) : diff;

  assign res.value   = value;
  assign res.mag     = mag_now;
  assign res.too_far = diff_abs > {1'b0, change_limit};

endmodule

>>> rtl/todu_merge.sv
module todu_merge (
  input  logic                sample,
  input  logic                wide_screen,
  input  logic [15:0]         flat_limit,
  input  logic [15:0]         dead_band,
  input  todu_pkg::orient_t   held,
  input  todu_pkg::lane_res_t lane_x,
  input  todu_pkg::lane_res_t lane_y,
  input  todu_pkg::lane_res_t lane_z,
  output todu_pkg::decision_t dec
);

  logic              stable;
  logic              x_gt;
  logic [15:0]       dxy;
  logic              decide;
  todu_pkg::orient_t cand;
  todu_pkg::orient_t orient;

  assign stable = sample & ~lane_x.too_far & ~lane_y.too_far & ~lane_z.too_far;
  assign x_gt   = lane_x.mag > lane_y.mag;
  assign dxy    = x_gt ? (lane_x.mag - lane_y.mag) : (lane_y.mag - lane_x.mag);
  // equal magnitudes fall to the y case
  assign cand   = x_gt ?
                  (lane_x.value[15] ? todu_pkg::ORIENT_X_NEG : todu_pkg::ORIENT_X_POS) :
                  (lane_y.value[15] ? todu_pkg::ORIENT_Y_NEG : todu_pkg::ORIENT_Y_POS);
  assign decide = stable && (lane_z.mag <= flat_limit) && (dxy >= dead_band);
  assign orient = decide ? cand : held;

  assign dec.orientation = orient;
  assign dec.request     = stable & ~wide_screen;
  assign dec.code        = (stable & ~wide_screen) ? todu_pkg::tall_map(orient) : 2'd0;

endmodule

>>> rtl/tilt_orientation_detector_unit.sv
// Channel   Dir  Handshake            Payload
// in_       in   in_valid/in_stall    in_axis_x, in_axis_y, in_axis_z (s16 Q15)
// out_      out  out_valid/out_stall  out_orientation, out_sampled,
//                                     out_rotation_request, out_rotation_code
// cfg_      in   cfg_valid/cfg_ready  cfg_index (2b), cfg_data (16b)
//
// One request per cycle sustained while in_stall is low; each accepted result
// is registered into the output register, or the skid if output is stalled.
// Three axis lanes plus merge are combinational; a two-entry output (register
// + skid) takes one more request under output stall; in_stall rises only then.
// rst_n is synchronous, active low; thresholds return to their defaults.
// cfg_ready is always high; writes are expected while the block is idle.
module tilt_orientation_detector_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_axis_x,
  input  logic [15:0] in_axis_y,
  input  logic [15:0] in_axis_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_orientation,
  output logic        out_sampled,
  output logic        out_rotation_request,
  output logic [1:0]  out_rotation_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration
  logic        wide_r;
  logic [15:0] change_limit_r;
  logic [15:0] flat_limit_r;
  logic [15:0] dead_band_r;

  // detector state
  logic [todu_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic signed [15:0]           last_x_r, last_y_r, last_z_r;
  todu_pkg::orient_t            held_r;

  // output register and skid
  logic                 out_valid_r, skid_valid_r;
  todu_pkg::out_item_t  out_r, skid_r, item;

  logic                 in_acc, out_take, sample;
  todu_pkg::lane_res_t  lane_x, lane_y, lane_z;
  todu_pkg::decision_t  dec;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid & ~skid_valid_r;
  assign out_take  = out_valid_r & ~out_stall;

  // tick counter; sample when it wraps to zero
  assign phase_nxt = (phase_r + todu_pkg::PHASE_W'(1)) & todu_pkg::PHASE_MASK;
  assign sample    = (phase_nxt == '0);

  // lanes: x and y negated in wide mode, z never
  todu_axis_lane u_lane_x (
    .axis(in_axis_x), .negate(wide_r), .last(last_x_r),
    .change_limit(change_limit_r), .res(lane_x)
  );
  todu_axis_lane u_lane_y (
    .axis(in_axis_y), .negate(wide_r), .last(last_y_r),
    .change_limit(change_limit_r), .res(lane_y)
  );
  todu_axis_lane u_lane_z (
    .axis(in_axis_z), .negate(1'b0), .last(last_z_r),
    .change_limit(change_limit_r), .res(lane_z)
  );

  todu_merge u_merge (
    .sample(sample), .wide_screen(wide_r), .flat_limit(flat_limit_r),
    .dead_band(dead_band_r), .held(held_r),
    .lane_x(lane_x), .lane_y(lane_y), .lane_z(lane_z), .dec(dec)
  );

  assign item.orientation = dec.orientation;
  assign item.sampled     = sample;
  assign item.request     = dec.request;
  assign item.code        = dec.code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r         <= 1'b0;
      change_limit_r <= todu_pkg::CHANGE_LIMIT_RST;
      flat_limit_r   <= todu_pkg::FLAT_LIMIT_RST;
      dead_band_r    <= todu_pkg::DEAD_BAND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (todu_pkg::cfg_reg_t'(cfg_index))
        todu_pkg::REG_WIDE_SCREEN:  wide_r         <= cfg_data[0];
        todu_pkg::REG_CHANGE_LIMIT: change_limit_r <= cfg_data;
        todu_pkg::REG_FLAT_LIMIT:   flat_limit_r   <= cfg_data;
        todu_pkg::REG_DEAD_BAND:    dead_band_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // state moves on every accepted tick; stored sample only on sample ticks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      last_x_r <= '0;
      last_y_r <= '0;
      last_z_r <= '0;
      held_r   <= todu_pkg::ORIENT_X_POS;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      held_r  <= dec.orientation;
      if (sample) begin
        last_x_r <= lane_x.value;
        last_y_r <= lane_y.value;
        last_z_r <= lane_z.value;
      end
    end
  end

  // output register with one-entry skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_r       <= item;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= item;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_orientation      = out_r.orientation;
  assign out_sampled          = out_r.sampled;
  assign out_rotation_request = out_r.request;
  assign out_rotation_code    = out_r.code;

  // skid holds data only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid full while output register empty");

  // a request comes only from a sample tick and follows the tall table
  a_req_sampled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rotation_request) |->
      (out_sampled && out_rotation_code ==
       todu_pkg::tall_map(todu_pkg::orient_t'(out_orientation))))
    else $error("rotation request inconsistent with result");

  // stalled output must not be overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_r)))
    else $error("stalled result changed");

  // no request while wide mode is set
  a_wide_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && wide_r) |-> !dec.request)
    else $error("rotation request in wide mode");

endmodule

>>> tb/todu_checker.sv
module todu_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] in_axis_x,
  input  logic [15:0] in_axis_y,
  input  logic [15:0] in_axis_z,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_orientation,
  input  logic        out_sampled,
  input  logic        out_rotation_request,
  input  logic [1:0]  out_rotation_code,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic        wide;
  logic [15:0] change_lim;
  logic [15:0] flat_lim;
  logic [15:0] dead_lim;

  // tilt tracker state
  logic [todu_pkg::PHASE_W-1:0] phase;
  logic signed [15:0]           prev_x, prev_y, prev_z;
  todu_pkg::orient_t            held;

  todu_pkg::out_item_t expected_q[$];
  todu_pkg::out_item_t want;
  int                  errors;

  assign fail_count = errors;

  task automatic report(input string msg);
    $display("checker: %s", msg);
    errors++;
  endtask

  function automatic int magn(input logic signed [15:0] v);
    int s;
    s = v;
    return (s < 0) ? -s : s;
  endfunction

  // wide mode flips x and y; the most negative code clips
  function automatic logic signed [15:0] flip_sat(input logic signed [15:0] v);
    return (v == 16'sh8000) ? 16'sh7fff : -v;
  endfunction

  function automatic bit jumped(input logic signed [15:0] a, input logic signed [15:0] b);
    int d;
    d = magn(a) - magn(b);
    if (d < 0) d = -d;
    return d > int'(change_lim);
  endfunction

  task automatic track_tick(input logic [15:0] xin, input logic [15:0] yin,
                            input logic [15:0] zin);
    logic signed [15:0]  x, y, z;
    int                  ax, ay, az;
    bit                  steady;
    todu_pkg::out_item_t item;
    item  = '0;
    phase = (phase + 1'b1) & todu_pkg::PHASE_MASK;
    if (phase == '0) begin
      x = xin;
      y = yin;
      z = zin;
      item.sampled = 1'b1;
      if (wide) begin
        x = flip_sat(x);
        y = flip_sat(y);
      end
      steady = !jumped(prev_x, x) && !jumped(prev_y, y) && !jumped(prev_z, z);
      prev_x = x;
      prev_y = y;
      prev_z = z;
      if (steady) begin
        ax = magn(x);
        ay = magn(y);
        az = magn(z);
        if (az <= int'(flat_lim)) begin
          // ties go to the y side
          if (ax > ay) begin
            if (ax - ay >= int'(dead_lim))
              held = (x < 0) ? todu_pkg::ORIENT_X_NEG : todu_pkg::ORIENT_X_POS;
          end else if (ay - ax >= int'(dead_lim)) begin
            held = (y < 0) ? todu_pkg::ORIENT_Y_NEG : todu_pkg::ORIENT_Y_POS;
          end
        end
        if (!wide) begin
          item.request = 1'b1;
          case (held)
            todu_pkg::ORIENT_X_POS: item.code = 2'd1;
            todu_pkg::ORIENT_Y_NEG: item.code = 2'd2;
            todu_pkg::ORIENT_X_NEG: item.code = 2'd3;
            default:                item.code = 2'd0;
          endcase
        end
      end
    end
    item.orientation = held;
    expected_q.push_back(item);
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      wide       = 1'b0;
      change_lim = todu_pkg::CHANGE_LIMIT_RST;
      flat_lim   = todu_pkg::FLAT_LIMIT_RST;
      dead_lim   = todu_pkg::DEAD_BAND_RST;
      phase      = '0;
      prev_x     = '0;
      prev_y     = '0;
      prev_z     = '0;
      held       = todu_pkg::ORIENT_X_POS;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (todu_pkg::cfg_reg_t'(cfg_index))
          todu_pkg::REG_WIDE_SCREEN:  wide       = cfg_data[0];
          todu_pkg::REG_CHANGE_LIMIT: change_lim = cfg_data;
          todu_pkg::REG_FLAT_LIMIT:   flat_lim   = cfg_data;
          todu_pkg::REG_DEAD_BAND:    dead_lim   = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("result with no request pending");
        end else begin
          want = expected_q.pop_front();
          if (out_orientation !== want.orientation)
            report($sformatf("orientation got %0d want %0d", out_orientation,
                             want.orientation));
          if (out_sampled !== want.sampled)
            report($sformatf("sampled got %0d want %0d", out_sampled, want.sampled));
          if (out_rotation_request !== want.request)
            report($sformatf("rotation_request got %0d want %0d", out_rotation_request,
                             want.request));
          if (out_rotation_code !== want.code)
            report($sformatf("rotation_code got %0d want %0d", out_rotation_code,
                             want.code));
        end
      end
      if (in_valid && !in_stall) track_tick(in_axis_x, in_axis_y, in_axis_z);
    end
    pending = expected_q.size();
  end

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PERIOD_TICKS = 1 << todu_pkg::SAMPLE_EVERY_LOG2;
  // far above the slowest legal run: ~1700 requests, each with a long
  // sender gap plus a long result stall
  localparam int CYCLE_LIMIT  = 1000000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_axis_x, in_axis_y, in_axis_z;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_orientation;
  logic        out_sampled;
  logic        out_rotation_request;
  logic [1:0]  out_rotation_code;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int pending;
  int ticks_sent;
  int cycles;
  bit calm;          // when set neither side idles
  int wx, wy, wz;    // slowly moving tilt vector, raw axis space

  tilt_orientation_detector_unit u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_axis_x            (in_axis_x),
    .in_axis_y            (in_axis_y),
    .in_axis_z            (in_axis_z),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_orientation      (out_orientation),
    .out_sampled          (out_sampled),
    .out_rotation_request (out_rotation_request),
    .out_rotation_code    (out_rotation_code),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  todu_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_axis_x            (in_axis_x),
    .in_axis_y            (in_axis_y),
    .in_axis_z            (in_axis_z),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_orientation      (out_orientation),
    .out_sampled          (out_sampled),
    .out_rotation_request (out_rotation_request),
    .out_rotation_code    (out_rotation_code),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .fail_count           (fail_count),
    .pending              (pending)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // gap length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm)   return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [15:0] clamp16(input int v);
    if (v > 32767)  return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // one step of the tilt walk on a single axis; a few steps snap to an extreme or to zero
  function automatic int walk(input int v, input int step);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return -32768;
    if (r < 4) return 32767;
    if (r < 5) return 0;
    return $signed(clamp16(v + int'($urandom_range(0, 2 * step)) - step));
  endfunction

  // result side: random stall bursts, released while calm
  initial begin
    int  hold;
    bit  st;
    out_stall = 1'b0;
    hold      = 0;
    st        = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        st   = !calm && ($urandom_range(0, 99) < 30);
        hold = st ? pick_gap() + 1 : $urandom_range(1, 8);
      end
      hold--;
      out_stall <= st;
    end
  end

  // Called at a falling edge. Leaves in_valid high unless a gap follows, so
  // back-to-back requests never see a low/high pair in one step.
  task automatic issue_tick(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z);
    int g;
    in_valid  <= 1'b1;
    in_axis_x <= x;
    in_axis_y <= y;
    in_axis_z <= z;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    ticks_sent++;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // pads with random ticks up to the next sampling tick, then sends the sample
  task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
    while ((ticks_sent % PERIOD_TICKS) != PERIOD_TICKS - 1)
      issue_tick(16'($urandom()), 16'($urandom()), 16'($urandom()));
    issue_tick(x, y, z);
  endtask

  // hold the sender until every request has its result back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input todu_pkg::cfg_reg_t idx, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // block is idle here; all four registers are rewritten every time
  task automatic set_config(input logic wide, input logic [15:0] chg,
                            input logic [15:0] flat, input logic [15:0] dead);
    write_reg(todu_pkg::REG_WIDE_SCREEN, {15'd0, wide});
    write_reg(todu_pkg::REG_CHANGE_LIMIT, chg);
    write_reg(todu_pkg::REG_FLAT_LIMIT, flat);
    write_reg(todu_pkg::REG_DEAD_BAND, dead);
    cfg_valid <= 1'b0;
  endtask

  // threshold: mostly inside Q15 range, sometimes above it
  function automatic logic [15:0] pick_thresh();
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(32769, 65535));
    return 16'($urandom_range(0, 32768));
  endfunction

  // Random phase. Sampling ticks mostly follow a slow tilt walk so the
  // change limit lets decisions through; some samples jump or are noise.
  // Off-sample ticks carry arbitrary data, which the block must ignore.
  task automatic run_phase(input int n_ticks, input int step_max);
    int r, step;
    for (int i = 0; i < n_ticks; i++) begin
      if (i % 64 == 0) calm = ($urandom_range(0, 4) == 0);
      if (i == n_ticks / 2) drain();
      if ((ticks_sent % PERIOD_TICKS) != PERIOD_TICKS - 1) begin
        issue_tick(16'($urandom()), 16'($urandom()), 16'($urandom()));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // noise sample, walk untouched
          issue_tick(16'($urandom()), 16'($urandom()), 16'($urandom()));
        end else begin
          if (r < 18) begin
            wx = $signed(16'($urandom()));
            wy = $signed(16'($urandom()));
            wz = $signed(16'($urandom()));
          end else begin
            step = $urandom_range(0, step_max);
            wx = walk(wx, step);
            wy = walk(wy, step);
            wz = walk(wz, step);
          end
          issue_tick(clamp16(wx), clamp16(wy), clamp16(wz));
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_axis_x  = '0;
    in_axis_y  = '0;
    in_axis_z  = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    ticks_sent = 0;
    cycles     = 0;
    calm       = 1'b0;
    wx = 0;
    wy = 0;
    wz = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset thresholds: each orientation, then a tie, a fast move
    send_sample(16'd0, 16'd0, 16'd0);
    send_sample(16'd3000, 16'd0, 16'd0);
    send_sample(16'd0, -16'sd3000, 16'd0);
    send_sample(-16'sd3000, 16'd0, 16'd0);
    send_sample(16'd0, 16'd3000, 16'd0);
    send_sample(16'd2000, 16'd2000, 16'd0);
    send_sample(16'h7fff, 16'd0, 16'd0);
    send_sample(16'h7fff, -16'sd3000, 16'd0);

    // open change limit: axis extremes, flat edge
    drain();
    set_config(1'b0, 16'hffff, todu_pkg::FLAT_LIMIT_RST, todu_pkg::DEAD_BAND_RST);
    send_sample(16'h8000, 16'h8000, 16'd0);
    send_sample(16'h8000, 16'h7fff, 16'd0);
    send_sample(16'd100, 16'h8000, 16'h8000);
    send_sample(16'd0, 16'd0, 16'd29491);
    send_sample(16'd0, 16'd0, 16'd29492);

    // wide display: clipped negation, no rotation
    drain();
    set_config(1'b1, 16'hffff, todu_pkg::FLAT_LIMIT_RST, todu_pkg::DEAD_BAND_RST);
    send_sample(16'h8000, 16'd5, 16'd0);
    send_sample(16'd5, 16'h8000, 16'd0);
    drain();
    set_config(1'b1, 16'hffff, todu_pkg::FLAT_LIMIT_RST, 16'd0);
    send_sample(16'd0, 16'd0, 16'd0);
    send_sample(16'h8000, 16'h8000, 16'h7fff);

    // random phases across settings, extremes included
    drain();
    set_config(1'b0, todu_pkg::CHANGE_LIMIT_RST, todu_pkg::FLAT_LIMIT_RST,
               todu_pkg::DEAD_BAND_RST);
    run_phase(300, 3000);
    drain();
    set_config(1'b1, todu_pkg::CHANGE_LIMIT_RST, todu_pkg::FLAT_LIMIT_RST,
               todu_pkg::DEAD_BAND_RST);
    run_phase(250, 3000);
    drain();
    set_config(1'b0, 16'd0, 16'd0, 16'd0);
    run_phase(150, 0);
    drain();
    set_config(1'b0, 16'hffff, 16'hffff, 16'hffff);
    run_phase(150, 32767);
    drain();
    set_config(1'b1, 16'd32768, 16'd32768, 16'd32768);
    run_phase(150, 8000);
    repeat (3) begin
      drain();
      set_config(1'($urandom_range(0, 1)), pick_thresh(), pick_thresh(), pick_thresh());
      run_phase(200, $urandom_range(0, 6000));
    end

    // wait out every result, then keep the clock running to catch stray ones
    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
